// ===== hdl/mstm_pkg.sv =====
package mstm_pkg;

    localparam int NUM_SOURCES  = 8;
    localparam int SOURCE_DEPTH = 256;
    localparam int SRC_W        = 3;
    localparam int ADDR_W       = $clog2(SOURCE_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int SCAN_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int STAMP_W      = 64;
    localparam int HANDLE_W     = 32;
    localparam int KIND_W       = 2;
    localparam int ENTRY_W      = STAMP_W + KIND_W + HANDLE_W;
    localparam int CFG_W        = 4;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_POPPED  = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    localparam logic [1:0] KIND_PARENT = 2'd0;
    localparam logic [1:0] KIND_MKDIR  = 2'd1;
    localparam logic [1:0] KIND_RENAME = 2'd2;
    localparam logic [1:0] KIND_RMDIR  = 2'd3;

    localparam logic [4:0] RAW_CREATE = 5'd1;
    localparam logic [4:0] RAW_MKDIR  = 5'd2;
    localparam logic [4:0] RAW_MKNOD  = 5'd5;
    localparam logic [4:0] RAW_RMDIR  = 5'd7;
    localparam logic [4:0] RAW_RENAME = 5'd8;

    localparam logic REG_NUM_SOURCES = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WARM,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [SRC_W-1:0]    source_index;
        logic [4:0]          change_type;
        logic [STAMP_W-1:0]  stamp;
        logic [HANDLE_W-1:0] payload_handle;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [SRC_W-1:0]    out_source;
        logic [KIND_W-1:0]   out_kind;
        logic [STAMP_W-1:0]  out_stamp;
        logic [HANDLE_W-1:0] out_handle;
    } out_item_t;

    typedef struct packed {
        logic push;
        logic clear;
        logic take;
    } cell_cmd_t;

    typedef struct packed {
        logic                found;
        logic [SRC_W-1:0]    src;
        logic [KIND_W-1:0]   kind;
        logic [STAMP_W-1:0]  stamp;
        logic [HANDLE_W-1:0] handle;
    } cand_t;

    // Returns {keep, kind}; keep low means the type is dropped.
    function automatic logic [2:0] classify(input logic [4:0] raw);
        logic [2:0] r;
        case (raw)
            RAW_MKDIR:             r = {1'b1, KIND_MKDIR};
            RAW_RENAME:            r = {1'b1, KIND_RENAME};
            RAW_RMDIR:             r = {1'b1, KIND_RMDIR};
            RAW_CREATE, RAW_MKNOD: r = {1'b1, KIND_PARENT};
            default:               r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/mstm_ram.sv =====
module mstm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/mstm_cell.sv =====
module mstm_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [mstm_pkg::SRC_W-1:0]   cell_index,
    input  logic [mstm_pkg::CFG_W-1:0]   num_sources,
    input  mstm_pkg::cell_cmd_t          cmd,
    input  logic [mstm_pkg::ENTRY_W-1:0] wr_entry,
    input  mstm_pkg::cand_t              cand_in,
    output mstm_pkg::cand_t              cand_out,
    output logic                         full
);

    logic [mstm_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic [mstm_pkg::CNT_W-1:0]   rp_reg, rp_next;
    logic [mstm_pkg::ENTRY_W-1:0] head;
    mstm_pkg::cand_t              cand_reg, cand_next;
    logic                         own_valid;

    // The read port always follows the read position, so after any push or take the
    // head is current once the RAM's registered read has caught up.
    mstm_ram #(
        .WIDTH(mstm_pkg::ENTRY_W),
        .DEPTH(mstm_pkg::SOURCE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (cmd.push),
        .waddr(fill_reg[mstm_pkg::ADDR_W-1:0]),
        .wdata(wr_entry),
        .raddr(rp_reg[mstm_pkg::ADDR_W-1:0]),
        .rdata(head)
    );

    always_comb
    begin
        fill_next = fill_reg;
        rp_next   = rp_reg;
        if (cmd.clear)
        begin
            fill_next = '0;
            rp_next   = '0;
        end
        else
        begin
            if (cmd.push)
            begin
                fill_next = fill_reg + 1'b1;
            end
            if (cmd.take)
            begin
                rp_next = rp_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        own_valid = ({1'b0, cell_index} < {1'b0, num_sources}) && (rp_reg < fill_reg);
        cand_next = cand_in;
        // Strictly less keeps the earlier, lower source on equal stamps.
        if (own_valid && (!cand_in.found ||
            head[mstm_pkg::ENTRY_W-1 -: mstm_pkg::STAMP_W] < cand_in.stamp))
        begin
            cand_next.found  = 1'b1;
            cand_next.src    = cell_index;
            cand_next.stamp  = head[mstm_pkg::ENTRY_W-1 -: mstm_pkg::STAMP_W];
            cand_next.kind   = head[mstm_pkg::HANDLE_W +: mstm_pkg::KIND_W];
            cand_next.handle = head[mstm_pkg::HANDLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            rp_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            rp_reg   <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;
    assign full     = (fill_reg >= mstm_pkg::CNT_W'(mstm_pkg::SOURCE_DEPTH));

endmodule

// ===== hdl/multi_source_timestamp_merge.sv =====
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     mstm_pkg::in_item_t
// out       output     out_valid / out_ready   mstm_pkg::out_item_t
// cfg       input      APB psel/penable/pwrite num_sources at address 0
//
// A push or a clear takes effect at its transfer; its result goes to the pending
// register and then to the output register. A pop waits in a warm-up state for
// the head reads and then runs through the chain of source cells, one cell per
// cycle, before its result takes the same path. One item is in work at a time; a
// new result waits while the output register still holds one.
// Reset empties every source; entry storage is not cleared.
module multi_source_timestamp_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mstm_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mstm_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    mstm_pkg::state_t                 state_reg, state_next;
    logic [mstm_pkg::SCAN_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [mstm_pkg::CFG_W-1:0]       num_src_reg;
    mstm_pkg::out_item_t              pend_reg, pend_next;
    mstm_pkg::out_item_t              out_reg;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_load;
    logic                             in_xfer;
    logic [2:0]                       cls;
    logic [mstm_pkg::ENTRY_W-1:0]     wr_entry;
    mstm_pkg::cell_cmd_t              cmd [mstm_pkg::NUM_SOURCES];
    mstm_pkg::cand_t                  chain [mstm_pkg::NUM_SOURCES+1];
    logic [mstm_pkg::NUM_SOURCES-1:0] full_vec;
    logic [mstm_pkg::NUM_SOURCES-1:0] take_vec;

    assign pready = 1'b1;
    assign prdata = {28'd0, num_src_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_src_reg <= 4'd1;
        end
        else if (psel && penable && pwrite && paddr[2] == mstm_pkg::REG_NUM_SOURCES)
        begin
            num_src_reg <= pwdata[mstm_pkg::CFG_W-1:0];
        end
    end

    assign in_ready = (state_reg == mstm_pkg::S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign cls      = mstm_pkg::classify(in_data.change_type);
    assign wr_entry = {in_data.stamp, cls[1:0], in_data.payload_handle};
    assign out_load = (state_reg == mstm_pkg::S_RESP) && (!out_valid_reg || out_ready);

    assign chain[0] = '0;

    for (genvar i = 0; i < mstm_pkg::NUM_SOURCES; i++)
    begin : g_cell
        always_comb
        begin
            cmd[i].clear = in_xfer && in_data.op == mstm_pkg::OP_CLEAR;
            cmd[i].push  = in_xfer && in_data.op == mstm_pkg::OP_PUSH && cls[2]
                           && in_data.source_index == mstm_pkg::SRC_W'(i) && !full_vec[i];
            cmd[i].take  = out_load && pend_reg.status == mstm_pkg::ST_POPPED
                           && pend_reg.out_source == mstm_pkg::SRC_W'(i);
            take_vec[i]  = cmd[i].take;
        end

        mstm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (mstm_pkg::SRC_W'(i)),
            .num_sources(num_src_reg),
            .cmd        (cmd[i]),
            .wr_entry   (wr_entry),
            .cand_in    (chain[i]),
            .cand_out   (chain[i+1]),
            .full       (full_vec[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            mstm_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    pend_next = '0;
                    case (in_data.op)
                        mstm_pkg::OP_PUSH:
                        begin
                            if (!cls[2])
                            begin
                                pend_next.status = mstm_pkg::ST_DROPPED;
                            end
                            else if (full_vec[in_data.source_index])
                            begin
                                pend_next.status = mstm_pkg::ST_FULL;
                            end
                            else
                            begin
                                pend_next.status = mstm_pkg::ST_STORED;
                            end
                            state_next = mstm_pkg::S_RESP;
                        end
                        mstm_pkg::OP_POP:
                        begin
                            scan_cnt_next = '0;
                            state_next    = mstm_pkg::S_WARM;
                        end
                        mstm_pkg::OP_CLEAR:
                        begin
                            pend_next.status = mstm_pkg::ST_CLEARED;
                            state_next       = mstm_pkg::S_RESP;
                        end
                        default:
                        begin
                            pend_next.status = mstm_pkg::ST_DROPPED;
                            state_next       = mstm_pkg::S_RESP;
                        end
                    endcase
                end
            end
            mstm_pkg::S_WARM:
            begin
                state_next = mstm_pkg::S_SCAN;
            end
            mstm_pkg::S_SCAN:
            begin
                // The last cell holds the final winner once every cell has seen
                // stable heads.
                if (scan_cnt_reg == mstm_pkg::SCAN_W'(mstm_pkg::NUM_SOURCES - 1))
                begin
                    pend_next = '0;
                    if (chain[mstm_pkg::NUM_SOURCES].found)
                    begin
                        pend_next.status     = mstm_pkg::ST_POPPED;
                        pend_next.out_source = chain[mstm_pkg::NUM_SOURCES].src;
                        pend_next.out_kind   = chain[mstm_pkg::NUM_SOURCES].kind;
                        pend_next.out_stamp  = chain[mstm_pkg::NUM_SOURCES].stamp;
                        pend_next.out_handle = chain[mstm_pkg::NUM_SOURCES].handle;
                    end
                    else
                    begin
                        pend_next.status = mstm_pkg::ST_EMPTY;
                    end
                    state_next = mstm_pkg::S_RESP;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            mstm_pkg::S_RESP:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = mstm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mstm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mstm_pkg::S_IDLE;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (out_load)
        begin
            out_reg <= pend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_take_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(take_vec))
        else $error("more than one source advanced by a pop");

    a_take_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (take_vec != '0) |-> (state_reg == mstm_pkg::S_RESP))
        else $error("source advanced outside the response state");

    a_resp_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid && state_reg == mstm_pkg::S_IDLE))
        else $error("result load did not show at the output");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mstm_pkg::S_SCAN)
        |-> (scan_cnt_reg <= mstm_pkg::SCAN_W'(mstm_pkg::NUM_SOURCES - 1)))
        else $error("scan counter ran past the last cell");

endmodule

// ===== dv/tb_multi_source_timestamp_merge.sv =====
module tb_multi_source_timestamp_merge;

    localparam int DRAIN_CYCLES = mstm_pkg::NUM_SOURCES + 8;
    localparam int IN_W         = $bits(mstm_pkg::in_item_t);

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    mstm_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    mstm_pkg::out_item_t out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    multi_source_timestamp_merge dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor state.
    logic [mstm_pkg::STAMP_W-1:0]
        rec_stamp  [mstm_pkg::NUM_SOURCES][mstm_pkg::SOURCE_DEPTH];
    logic [mstm_pkg::KIND_W-1:0]
        rec_kind   [mstm_pkg::NUM_SOURCES][mstm_pkg::SOURCE_DEPTH];
    logic [mstm_pkg::HANDLE_W-1:0]
        rec_handle [mstm_pkg::NUM_SOURCES][mstm_pkg::SOURCE_DEPTH];
    int unsigned                fill_level [mstm_pkg::NUM_SOURCES];
    int unsigned                read_ptr   [mstm_pkg::NUM_SOURCES];
    logic [mstm_pkg::CFG_W-1:0] scan_count;

    mstm_pkg::in_item_t  pending_items[$];
    mstm_pkg::out_item_t expected_results[$];
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  error_count;
    int                  pops_seen;
    int                  full_seen;
    logic                in_ready_seen;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic mstm_pkg::out_item_t merge_predict(input mstm_pkg::in_item_t item);
        mstm_pkg::out_item_t res;
        logic [2:0]          cls;
        int unsigned         limit;
        bit                  found;
        int unsigned         best;
        res = '0;
        best = 0;
        found = 1'b0;
        case (item.op)
            mstm_pkg::OP_PUSH:
            begin
                cls = 3'b000;
                case (item.change_type)
                    mstm_pkg::RAW_MKDIR:  cls = {1'b1, mstm_pkg::KIND_MKDIR};
                    mstm_pkg::RAW_RENAME: cls = {1'b1, mstm_pkg::KIND_RENAME};
                    mstm_pkg::RAW_RMDIR:  cls = {1'b1, mstm_pkg::KIND_RMDIR};
                    mstm_pkg::RAW_CREATE, mstm_pkg::RAW_MKNOD:
                        cls = {1'b1, mstm_pkg::KIND_PARENT};
                    default:              cls = 3'b000;
                endcase
                if (!cls[2])
                    res.status = mstm_pkg::ST_DROPPED;
                else if (item.source_index >= mstm_pkg::NUM_SOURCES
                         || fill_level[item.source_index] >= mstm_pkg::SOURCE_DEPTH)
                    res.status = mstm_pkg::ST_FULL;
                else
                begin
                    rec_stamp[item.source_index][fill_level[item.source_index]] = item.stamp;
                    rec_kind[item.source_index][fill_level[item.source_index]] = cls[1:0];
                    rec_handle[item.source_index][fill_level[item.source_index]] =
                        item.payload_handle;
                    fill_level[item.source_index]++;
                    res.status = mstm_pkg::ST_STORED;
                end
            end
            mstm_pkg::OP_POP:
            begin
                limit = (scan_count > mstm_pkg::NUM_SOURCES) ? mstm_pkg::NUM_SOURCES
                                                             : scan_count;
                for (int s = 0; s < limit; s++)
                begin
                    if (read_ptr[s] < fill_level[s])
                    begin
                        if (!found || rec_stamp[s][read_ptr[s]] < rec_stamp[best][read_ptr[best]])
                        begin
                            found = 1'b1;
                            best = s;
                        end
                    end
                end
                if (found)
                begin
                    res.status     = mstm_pkg::ST_POPPED;
                    res.out_source = best[mstm_pkg::SRC_W-1:0];
                    res.out_kind   = rec_kind[best][read_ptr[best]];
                    res.out_stamp  = rec_stamp[best][read_ptr[best]];
                    res.out_handle = rec_handle[best][read_ptr[best]];
                    read_ptr[best]++;
                end
                else
                    res.status = mstm_pkg::ST_EMPTY;
            end
            mstm_pkg::OP_CLEAR:
            begin
                for (int s = 0; s < mstm_pkg::NUM_SOURCES; s++)
                begin
                    fill_level[s] = 0;
                    read_ptr[s] = 0;
                end
                res.status = mstm_pkg::ST_CLEARED;
            end
            default: res.status = mstm_pkg::ST_DROPPED;
        endcase
        return res;
    endfunction

    // Driver: one transfer per accepted handshake, next item placed at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready_seen)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Acceptance is noted at the rising edge so the driver knows the item is gone.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ready_seen <= 1'b0;
        else
        begin
            in_ready_seen <= in_valid && in_ready;
            if (in_valid && in_ready)
                expected_results.push_back(merge_predict(in_data));
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        mstm_pkg::out_item_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", out_data);
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (out_data.status == mstm_pkg::ST_POPPED)
                    pops_seen++;
                if (out_data.status == mstm_pkg::ST_FULL)
                    full_seen++;
                if (out_data.status !== exp_res.status)
                begin
                    $error("status expected %0d actual %0d", exp_res.status, out_data.status);
                    error_count++;
                end
                if (out_data.out_source !== exp_res.out_source)
                begin
                    $error("out_source expected %0d actual %0d",
                           exp_res.out_source, out_data.out_source);
                    error_count++;
                end
                if (out_data.out_kind !== exp_res.out_kind)
                begin
                    $error("out_kind expected %0d actual %0d",
                           exp_res.out_kind, out_data.out_kind);
                    error_count++;
                end
                if (out_data.out_stamp !== exp_res.out_stamp)
                begin
                    $error("out_stamp expected %h actual %h",
                           exp_res.out_stamp, out_data.out_stamp);
                    error_count++;
                end
                if (out_data.out_handle !== exp_res.out_handle)
                begin
                    $error("out_handle expected %h actual %h",
                           exp_res.out_handle, out_data.out_handle);
                    error_count++;
                end
            end
        end
    end

    function automatic mstm_pkg::in_item_t make_push(input int src, input logic [4:0] raw,
                                                     input logic [63:0] stamp,
                                                     input logic [31:0] hnd);
        mstm_pkg::in_item_t it;
        it.op             = mstm_pkg::OP_PUSH;
        it.source_index   = src[mstm_pkg::SRC_W-1:0];
        it.change_type    = raw;
        it.stamp          = stamp;
        it.payload_handle = hnd;
        return it;
    endfunction

    function automatic mstm_pkg::in_item_t make_op(input logic [1:0] op);
        mstm_pkg::in_item_t it;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom});
        it.op = op;
        return it;
    endfunction

    function automatic logic [4:0] pick_raw();
        logic [4:0] raws[5];
        raws = '{mstm_pkg::RAW_CREATE, mstm_pkg::RAW_MKDIR, mstm_pkg::RAW_MKNOD,
                 mstm_pkg::RAW_RMDIR, mstm_pkg::RAW_RENAME};
        if ($urandom_range(9) == 0)
            return 5'($urandom);
        return raws[$urandom_range(4)];
    endfunction

    function automatic logic [63:0] pick_stamp();
        // Narrow stamps make ties between sources frequent.
        case ($urandom_range(3))
            0: return 64'($urandom_range(7));
            1: return {34'($urandom_range(3)), 30'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_num_sources(input logic [3:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {mstm_pkg::REG_NUM_SOURCES, 2'b00};
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        scan_count = value;
    endtask

    // Mostly well-formed items in random order: pushes spread over all sources, pops, rare clears and undefined ops.
    task automatic queue_random(input int count);
        int n;
        n = 0;
        while (n < count)
        begin
            case ($urandom_range(19))
                0: pending_items.push_back(make_op(mstm_pkg::OP_CLEAR));
                1: pending_items.push_back(make_op(2'd3));
                2, 3, 4, 5, 6, 7, 8, 9:
                    pending_items.push_back(
                        make_push($urandom_range(mstm_pkg::NUM_SOURCES - 1),
                                  pick_raw(), pick_stamp(), $urandom));
                default: pending_items.push_back(make_op(mstm_pkg::OP_POP));
            endcase
            n++;
        end
    endtask

    initial
    begin
        logic [3:0] settings[6];
        settings = '{4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd1};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        pops_seen = 0;
        full_seen = 0;
        scan_count = 4'd1;
        for (int s = 0; s < mstm_pkg::NUM_SOURCES; s++)
        begin
            fill_level[s] = 0;
            read_ptr[s] = 0;
        end
        send_idle_pct = 31;
        recv_idle_pct = 65;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset setting scans one source; pop on empty, unscanned source, dropped types.
        pending_items.push_back(make_op(mstm_pkg::OP_POP));
        pending_items.push_back(make_push(1, mstm_pkg::RAW_MKDIR, 64'd5, 32'h1));
        pending_items.push_back(make_op(mstm_pkg::OP_POP));
        pending_items.push_back(make_push(0, mstm_pkg::RAW_CREATE, '1, '1));
        pending_items.push_back(make_push(0, mstm_pkg::RAW_MKNOD, '0, '0));
        pending_items.push_back(make_push(0, 5'd31, 64'd9, 32'h9));
        pending_items.push_back(make_push(0, 5'd0, 64'd9, 32'h9));
        pending_items.push_back(make_op(2'd3));
        pending_items.push_back(make_op(mstm_pkg::OP_POP));
        pending_items.push_back(make_op(mstm_pkg::OP_POP));
        pending_items.push_back(make_op(mstm_pkg::OP_POP));
        wait_drained();
        write_num_sources(4'd8);
        for (int s = 7; s >= 0; s--)
            pending_items.push_back(make_push(s, mstm_pkg::RAW_RENAME, 64'd100, 32'(s)));
        pending_items.push_back(make_push(3, mstm_pkg::RAW_RMDIR, 64'd50, 32'h33));
        for (int k = 0; k < 10; k++)
            pending_items.push_back(make_op(mstm_pkg::OP_POP));
        pending_items.push_back(make_op(mstm_pkg::OP_CLEAR));
        // Push SOURCE_DEPTH + 3 items to source 2; random types that are dropped may keep it short of full.
        for (int k = 0; k < mstm_pkg::SOURCE_DEPTH + 3; k++)
            pending_items.push_back(make_push(2, pick_raw(), pick_stamp(), $urandom));
        pending_items.push_back(make_op(mstm_pkg::OP_POP));
        pending_items.push_back(make_op(mstm_pkg::OP_CLEAR));

        // Random phases; each setting is applied while the block is idle.
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_num_sources(settings[ph]);
            if (ph == 2)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 31;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_random(215);
        end
        wait_drained();
        $display("Covered %0d popped records and %0d full or out-of-range pushes", pops_seen,
                 full_seen);
        $display("over num_sources settings 0, 1, 3, 5, 8 and 15 with clears and idling.");
        if (error_count == 0)
            $display("PASS multi_source_timestamp_merge");
        else
            $display("FAIL multi_source_timestamp_merge");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL multi_source_timestamp_merge");
        $finish;
    end

endmodule
